// File: rtl/wpet_pkg.sv
`timescale 1ns / 1ps

package wpet_pkg;

    // table size and per-tick result limit
    localparam int WPET_CAPACITY = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 16;
    localparam int SEC_W    = 31;
    localparam int NEXT_W   = 32;
    localparam int HANDLE_W = 16;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_FIRE   = 2'd1,
        CMD_SET    = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    // result kinds
    typedef enum logic {
        KIND_FIRED = 1'b0,
        KIND_FULL  = 1'b1
    } kind_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic [ID_W-1:0]     key;
        logic [SEC_W-1:0]    start_sec;
        logic [SEC_W-1:0]    end_sec;
        logic [SEC_W-1:0]    period_sec;
        logic [NEXT_W-1:0]   next_sec;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // one result word without its last flag
    typedef struct packed {
        kind_t               kind;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
    } res_t;

endpackage

// File: rtl/wpet_if.sv
`timescale 1ns / 1ps

// command word channel
interface wpet_item_if
    import wpet_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     event_id;
    logic [SEC_W-1:0]    start_sec;
    logic [SEC_W-1:0]    end_sec;
    logic [SEC_W-1:0]    period_sec;
    logic [HANDLE_W-1:0] message_handle;
    logic [SEC_W-1:0]    now_sec;

    modport source (
        output valid, cmd, event_id, start_sec, end_sec, period_sec,
               message_handle, now_sec,
        input  ready
    );
    modport sink (
        input  valid, cmd, event_id, start_sec, end_sec, period_sec,
               message_handle, now_sec,
        output ready
    );
endinterface

// result word channel
interface wpet_result_if
    import wpet_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [ID_W-1:0]     fired_id;
    logic [HANDLE_W-1:0] out_handle;
    logic                last;

    modport source (
        output valid, kind, fired_id, out_handle, last,
        input  ready
    );
    modport sink (
        input  valid, kind, fired_id, out_handle, last,
        output ready
    );
endinterface

// File: rtl/windowed_periodic_event_table.sv
`timescale 1ns / 1ps
// fire once: the result word goes through the pending register to the output register once that is free
// tick, set, delete: scan every slot, one slot read per cycle from the entry memory while no tick stalls
// a tick then moves its final result word from the pending register to the output in the flush state
// the next command word is taken only once the sequencer is back in idle, later while a waiting
// result word blocks the output register
// reset clears the slot-used bits, the sequencer and the output valid; entry memory is not cleared

module windowed_periodic_event_table
    import wpet_pkg::*;
#(
    parameter int CAPACITY = WPET_CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    wpet_item_if.sink     item,
    wpet_result_if.source result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // control and command registers
    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [SEC_W-1:0]     start_reg, start_next;
    logic [SEC_W-1:0]     end_reg, end_next;
    logic [SEC_W-1:0]     period_reg, period_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [SEC_W-1:0]     now_reg, now_next;

    // scan pipeline
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]     ev_idx_reg, ev_idx_next;
    logic [CAPACITY-1:0]  used_reg, used_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;

    // key search results
    logic                 match_found_reg, match_found_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;

    // pending and output result words
    logic                 pend_valid_reg, pend_valid_next;
    res_t                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, out_next;
    logic                 out_last_reg, out_last_next;

    // entry memory
    entry_t               mem [0:CAPACITY-1];
    entry_t               rd_q;
    logic                 rd_en;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    entry_t               mem_wdata;

    logic                 out_free;
    logic                 issue_ok;
    logic                 ev_used;
    logic                 ev_active;
    logic                 ev_expired;
    logic                 ev_due;
    logic                 tick_emit;
    logic                 stall;
    logic [NEXT_W-1:0]    rearm_sec;
    logic [NEXT_W-1:0]    set_next_sec;
    entry_t               set_entry;

    assign item.ready        = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.kind       = out_reg.kind;
    assign result.fired_id   = out_reg.id;
    assign result.out_handle = out_reg.handle;
    assign result.last       = out_last_reg;

    // evaluation of the entry read last cycle
    assign out_free   = !out_valid_reg || result.ready;
    assign issue_ok   = (rd_idx_reg < CNT_W'(CAPACITY));
    assign ev_used    = used_reg[ev_idx_reg];
    assign ev_expired = (rd_q.end_sec < now_reg);
    assign ev_active  = (rd_q.start_sec <= now_reg) && (rd_q.period_sec != '0);
    assign ev_due     = (rd_q.next_sec != '0) && (rd_q.next_sec <= {1'b0, now_reg})
                        && (n_reg < RES_CNT_W'(MAX_RESULTS));
    assign tick_emit  = ev_valid_reg && (cmd_reg == CMD_TICK) && ev_used
                        && !ev_expired && ev_active && ev_due;
    assign stall      = tick_emit && pend_valid_reg && !out_free;
    assign rearm_sec  = {1'b0, now_reg} + {1'b0, rd_q.period_sec};

    // entry written by a set
    assign set_next_sec = {1'b0, now_reg} + {1'b0, period_reg};
    always_comb
    begin
        set_entry.key        = id_reg;
        set_entry.start_sec  = start_reg;
        set_entry.end_sec    = end_reg;
        set_entry.period_sec = period_reg;
        set_entry.next_sec   = set_next_sec;
        set_entry.handle     = handle_reg;
    end

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        id_next          = id_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        period_next      = period_reg;
        handle_next      = handle_reg;
        now_next         = now_reg;
        rd_idx_next      = rd_idx_reg;
        ev_valid_next    = ev_valid_reg;
        ev_idx_next      = ev_idx_reg;
        used_next        = used_reg;
        n_next           = n_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        out_last_next    = out_last_reg;
        rd_en            = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = ev_idx_reg;
        mem_wdata        = rd_q;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    cmd_next         = cmd_t'(item.cmd);
                    id_next          = item.event_id;
                    start_next       = item.start_sec;
                    end_next         = item.end_sec;
                    period_next      = item.period_sec;
                    handle_next      = item.message_handle;
                    now_next         = item.now_sec;
                    rd_idx_next      = '0;
                    ev_valid_next    = 1'b0;
                    n_next           = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    if (cmd_t'(item.cmd) == CMD_FIRE)
                    begin
                        pend_valid_next = 1'b1;
                        pend_next.kind  = KIND_FIRED;
                        pend_next.id    = item.event_id;
                        pend_next.handle = item.message_handle;
                        state_next      = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    // evaluate the slot whose entry sits in the read register
                    if (ev_valid_reg)
                    begin
                        if (cmd_reg == CMD_TICK)
                        begin
                            if (ev_used && ev_expired)
                            begin
                                used_next[ev_idx_reg] = 1'b0;
                            end
                            else if (ev_used && ev_active && (rd_q.next_sec == '0))
                            begin
                                mem_we             = 1'b1;
                                mem_wdata.next_sec = rearm_sec;
                            end
                            else if (tick_emit)
                            begin
                                mem_we             = 1'b1;
                                mem_wdata.next_sec = rearm_sec;
                                n_next             = n_reg + RES_CNT_W'(1);
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next       = pend_reg;
                                    out_last_next  = 1'b0;
                                end
                                pend_valid_next  = 1'b1;
                                pend_next.kind   = KIND_FIRED;
                                pend_next.id     = rd_q.key;
                                pend_next.handle = rd_q.handle;
                            end
                        end
                        else
                        begin
                            if (ev_used && (rd_q.key == id_reg) && !match_found_reg)
                            begin
                                match_found_next = 1'b1;
                                match_idx_next   = ev_idx_reg;
                            end
                            if (!ev_used && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = ev_idx_reg;
                            end
                        end
                    end

                    // read the next slot
                    if (issue_ok)
                    begin
                        rd_en         = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                    end

                    // all slots seen: commit set or delete, or go on to flush
                    if (!ev_valid_reg && !issue_ok)
                    begin
                        case (cmd_reg)
                            CMD_SET:
                            begin
                                if (match_found_reg || free_found_reg)
                                begin
                                    mem_we    = 1'b1;
                                    mem_wdata = set_entry;
                                    mem_waddr = match_found_reg ? match_idx_reg
                                                                : free_idx_reg;
                                    used_next[mem_waddr] = 1'b1;
                                    state_next = ST_IDLE;
                                end
                                else
                                begin
                                    pend_valid_next  = 1'b1;
                                    pend_next.kind   = KIND_FULL;
                                    pend_next.id     = id_reg;
                                    pend_next.handle = handle_reg;
                                    state_next       = ST_FLUSH;
                                end
                            end
                            CMD_DELETE:
                            begin
                                if (match_found_reg)
                                begin
                                    used_next[match_idx_reg] = 1'b0;
                                end
                                state_next = ST_IDLE;
                            end
                            default:
                            begin
                                state_next = ST_FLUSH;
                            end
                        endcase
                    end
                end
            end

            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_next        = pend_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            used_reg        <= '0;
            ev_valid_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            rd_idx_reg      <= '0;
            n_reg           <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            ev_valid_reg    <= ev_valid_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
            rd_idx_reg      <= rd_idx_next;
            n_reg           <= n_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        id_reg        <= id_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        period_reg    <= period_next;
        handle_reg    <= handle_next;
        now_reg       <= now_next;
        ev_idx_reg    <= ev_idx_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_last_reg  <= out_last_next;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

endmodule
